/* sv/gctm_pkg.sv */
// Package with shared constants and types of the tri-colour marking engine.
`timescale 1ns / 1ps

package gctm_pkg;

	// Field widths fixed by the word format.
	localparam int OP_BITS     = 2;
	localparam int HANDLE_BITS = 12;
	localparam int STATUS_BITS = 2;

	// Command codes.
	localparam logic [OP_BITS-1:0] OP_BEGIN  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_REPORT = 2'd1;
	localparam logic [OP_BITS-1:0] OP_NEXT   = 2'd2;

	// Status codes.
	localparam logic [STATUS_BITS-1:0] STAT_OK            = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_GREY_PENDING  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_LIST_EMPTY    = 2'd2;

	// Result word handed from the sequencer to the output register.
	typedef struct packed {
		logic                   valid;
		logic [STATUS_BITS-1:0] status;
		logic [HANDLE_BITS-1:0] out_handle;
		logic                   newly_grey;
	} result_t;

endpackage

/* sv/gctm_req_if.sv */
// Command channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps

interface gctm_req_if
	import gctm_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [OP_BITS-1:0]     opcode;
	logic [HANDLE_BITS-1:0] obj_handle;

	modport source (output valid, output opcode, output obj_handle, input ready);
	modport sink (input valid, input opcode, input obj_handle, output ready);
endinterface

/* sv/gctm_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps

interface gctm_rsp_if
	import gctm_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [HANDLE_BITS-1:0] out_handle;
	logic                   newly_grey;

	modport source (output valid, output status, output out_handle, output newly_grey,
		input ready);
	modport sink (input valid, input status, input out_handle, input newly_grey,
		output ready);
endinterface

/* sv/gc_tricolour_mark_engine_core.sv */
// Each command is accepted in the idle state, then executed in the execute state, which
// waits while the output register is full; no new command is taken before it finishes. The
// execute step consumes the colour memory read issued at accept (a next command also writes
// back the finished object) and loads the result word into the output register. After reset
// a clearing pass writes every colour word to black while the command channel is held not
// ready; marking registers reset to an empty stack, no object in scan and white epoch one.
`timescale 1ns / 1ps

module gc_tricolour_mark_engine_core
	import gctm_pkg::*;
#(
	parameter int OBJECT_COUNT = 4096,
	parameter int EPOCH_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gctm_req_if.sink   req,
	gctm_rsp_if.source rsp
);

	localparam int AW = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
	localparam int LW = (EPOCH_BITS > HANDLE_BITS) ? EPOCH_BITS : HANDLE_BITS;
	localparam int DW = LW + 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;
	result_t       done;
	logic          out_free;
	logic          out_valid_q;
	result_t       out_q;

	gctm_colour_ram #(
		.DEPTH (OBJECT_COUNT),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gctm_ctrl #(
		.OBJECT_COUNT (OBJECT_COUNT),
		.EPOCH_BITS   (EPOCH_BITS),
		.AW           (AW),
		.DW           (DW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.done      (done),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Output register: the execute step may finish when the slot is empty or draining.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			out_q <= done;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.out_handle = out_q.out_handle;
	assign rsp.newly_grey = out_q.newly_grey;

endmodule

/* sv/gctm_colour_ram.sv */
// Colour word memory: one write port, one registered read port, write-first on collision.
`timescale 1ns / 1ps

module gctm_colour_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; a same-cycle write to the read address is forwarded.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/gctm_ctrl.sv */
// Command sequencer: clearing pass, memory read-modify-write and marking registers.
`timescale 1ns / 1ps

module gctm_ctrl
	import gctm_pkg::*;
#(
	parameter int OBJECT_COUNT = 4096,
	parameter int EPOCH_BITS   = 16,
	parameter int AW           = 12,
	parameter int DW           = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	gctm_req_if.sink      req,
	input  logic          out_free,
	output result_t       done,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [DW-1:0] mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [DW-1:0] mem_rdata
);

	localparam int LW = DW - 1;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0]             state_q;
	logic [AW-1:0]          clr_cnt_q;
	logic [HANDLE_BITS-1:0] head_q;
	logic [HANDLE_BITS-1:0] scan_q;
	logic [EPOCH_BITS-1:0]  epoch_q;
	logic [OP_BITS-1:0]     op_s1;
	logic [HANDLE_BITS-1:0] handle_s1;

	logic accept;
	logic clear_last;
	logic in_usable;
	logic head_usable;
	logic scan_usable;
	logic s1_usable;
	logic word_grey;
	logic report_hit;
	logic finish;

	// A handle names a table entry when it is not null and lies below the object count.
	function automatic logic usable(input logic [HANDLE_BITS-1:0] h);
		return (h != '0) && (32'(h) < 32'(OBJECT_COUNT));
	endfunction

	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && (state_q == S_IDLE);
	assign clear_last  = (clr_cnt_q == AW'(OBJECT_COUNT - 1));
	assign in_usable   = usable(req.obj_handle);
	assign head_usable = usable(head_q);
	assign scan_usable = usable(scan_q);
	assign s1_usable   = usable(handle_s1);
	assign word_grey   = mem_rdata[DW-1];
	assign report_hit  = s1_usable && !word_grey && (mem_rdata[EPOCH_BITS-1:0] != epoch_q);
	assign finish      = (state_q == S_EXEC) && out_free;

	// Memory port control: clearing, whitening on a next command, greying on a report.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = AW'(req.obj_handle);
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && (req.opcode == OP_NEXT)) begin
			mem_we    = scan_usable;
			mem_waddr = AW'(scan_q);
			mem_wdata = {1'b0, LW'(epoch_q)};
			mem_re    = head_usable;
			mem_raddr = AW'(head_q);
		end else if (accept && (req.opcode == OP_REPORT)) begin
			mem_re = in_usable;
		end else if (finish && (op_s1 == OP_REPORT) && report_hit) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(handle_s1);
			mem_wdata = {1'b1, LW'(head_q)};
		end
	end

	// Result of the command in the execute step.
	always_comb begin
		done            = '0;
		done.valid      = finish;
		unique case (op_s1)
			OP_BEGIN: begin
				if (head_q != '0) begin
					done.status = STAT_GREY_PENDING;
				end
			end
			OP_REPORT: begin
				done.newly_grey = report_hit;
			end
			OP_NEXT: begin
				if (head_usable) begin
					done.out_handle = head_q;
				end else begin
					done.status = STAT_LIST_EMPTY;
				end
			end
			default: begin
				done.status = STAT_OK;
			end
		endcase
	end

	// Sequencer state and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command word held for the execute step.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= req.opcode;
			handle_s1 <= req.obj_handle;
		end
	end

	// Marking registers: grey stack head, object in scan and white epoch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			scan_q  <= '0;
			epoch_q <= EPOCH_BITS'(1);
		end else if (finish) begin
			case (op_s1)
				OP_BEGIN: begin
					if (head_q == '0) begin
						epoch_q <= epoch_q + EPOCH_BITS'(2);
						scan_q  <= '0;
					end
				end
				OP_REPORT: begin
					if (report_hit) begin
						head_q <= handle_s1;
					end
				end
				OP_NEXT: begin
					if (head_usable) begin
						head_q <= mem_rdata[HANDLE_BITS-1:0];
						scan_q <= head_q;
					end else begin
						head_q <= '0;
						scan_q <= '0;
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

endmodule

/* sv/gctm_checker.sv */
// Port-level checker for the marking engine and its bind to the top level.
`timescale 1ns / 1ps

module gctm_checker
	import gctm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [STATUS_BITS-1:0] status,
	input logic [HANDLE_BITS-1:0] out_handle,
	input logic                   newly_grey
);

	// The engine works on one command word at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while the previous one is in execution");

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_handle)
			&& $stable(newly_grey))
		else $error("result word changed while stalled");

	// A newly greyed flag comes with an ok status and a null handle, as from a report.
	a_grey_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && newly_grey |-> (status == STAT_OK) && (out_handle == '0))
		else $error("newly grey flag with other result fields set");

	// A popped handle always comes with an ok status.
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (out_handle != '0) |-> (status == STAT_OK))
		else $error("popped handle with an error status");

endmodule

bind gc_tricolour_mark_engine_core gctm_checker u_gctm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.out_handle (rsp.out_handle),
	.newly_grey (rsp.newly_grey)
);

/* sim/tb_gc_tricolour_mark_engine_core.sv */
// Self-checking testbench for the tri-colour marking engine core.
`timescale 1ns / 1ps

module tb_gc_tricolour_mark_engine_core;
	import gctm_pkg::*;

	localparam int OBJECT_COUNT = 4096;
	localparam int EPOCH_BITS   = 16;
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 650;
	localparam int HOLD_CYCLES  = 400;

	// One result word as the engine should return it.
	typedef struct {
		logic [STATUS_BITS-1:0] status;
		logic [HANDLE_BITS-1:0] out_handle;
		logic                   newly_grey;
	} mark_result_t;

	// Mirror of the marking state plus the results still owed by the engine.
	class colour_tracker;
		bit                  grey_flag [OBJECT_COUNT];
		bit [EPOCH_BITS-1:0] colour_val [OBJECT_COUNT];
		logic [HANDLE_BITS-1:0] grey_head;
		logic [HANDLE_BITS-1:0] scan_handle;
		logic [EPOCH_BITS-1:0]  white_epoch;
		mark_result_t awaited_results[$];
		int mismatches;
		int results_seen;

		function new();
			grey_head    = '0;
			scan_handle  = '0;
			white_epoch  = EPOCH_BITS'(1);
			mismatches   = 0;
			results_seen = 0;
		endfunction

		// Apply one accepted word to the mirror and queue the result it causes.
		function void note_command(logic [OP_BITS-1:0] op, logic [HANDLE_BITS-1:0] h);
			mark_result_t r;
			logic [HANDLE_BITS-1:0] top;
			r.status     = STAT_OK;
			r.out_handle = '0;
			r.newly_grey = 1'b0;
			case (op)
				OP_BEGIN: begin
					if (grey_head != 0) begin
						r.status = STAT_GREY_PENDING;
					end else begin
						white_epoch = white_epoch + EPOCH_BITS'(2);
						scan_handle = '0;
					end
				end
				OP_REPORT: begin
					// Only a black object is pushed; grey and white ones are left alone.
					if (h != 0 && !grey_flag[h] && colour_val[h] != white_epoch) begin
						grey_flag[h]  = 1'b1;
						colour_val[h] = EPOCH_BITS'(grey_head);
						grey_head     = h;
						r.newly_grey  = 1'b1;
					end
				end
				OP_NEXT: begin
					if (scan_handle != 0) begin
						grey_flag[scan_handle]  = 1'b0;
						colour_val[scan_handle] = white_epoch;
					end
					if (grey_head == 0) begin
						scan_handle = '0;
						r.status    = STAT_LIST_EMPTY;
					end else begin
						top          = grey_head;
						grey_head    = colour_val[top][HANDLE_BITS-1:0];
						scan_handle  = top;
						r.out_handle = top;
					end
				end
				default: begin
				end
			endcase
			awaited_results.push_back(r);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		// Compare one accepted result word with the oldest expectation.
		task check_result(logic [STATUS_BITS-1:0] st, logic [HANDLE_BITS-1:0] oh,
				logic ng);
			mark_result_t e;
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d handle=%0d grey=%0d",
					st, oh, ng));
			end else begin
				e = awaited_results.pop_front();
				if (st !== e.status)
					report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
				if (oh !== e.out_handle)
					report_mismatch($sformatf("out_handle %0d, expected %0d", oh,
						e.out_handle));
				if (ng !== e.newly_grey)
					report_mismatch($sformatf("newly_grey %0d, expected %0d", ng,
						e.newly_grey));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	gctm_req_if req_ch();
	gctm_rsp_if rsp_ch();

	colour_tracker tracker;
	int burst_left;
	int effective_items;
	int idle_cycles;

	gc_tricolour_mark_engine_core #(
		.OBJECT_COUNT(OBJECT_COUNT),
		.EPOCH_BITS(EPOCH_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Sample both channels at the rising edge and watch for a hung engine.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				tracker.note_command(req_ch.opcode, req_ch.obj_handle);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				tracker.check_result(rsp_ch.status, rsp_ch.out_handle, rsp_ch.newly_grey);
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("gc_tricolour_mark_engine_core verification failed");
				$finish;
			end
		end
	end

	// Result receiver: stall pattern rotates through four modes, with one long hold-off.
	initial begin : receiver
		int rx_cycle;
		bit held_off;
		rx_cycle = 0;
		held_off = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (!held_off && tracker.results_seen >= 150) begin
				// Hold off long enough for the engine to back up into its input.
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				case ((rx_cycle / 64) % 4)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
					2: rsp_ch.ready <= (rx_cycle % 5 != 0);
					default: rsp_ch.ready <= (rx_cycle % 7 < 2);
				endcase
			end
		end
	end

	// Offer one command word in bursts with random gaps; returns at the falling edge
	// after the word has been accepted.
	task automatic send_word(logic [OP_BITS-1:0] op, logic [HANDLE_BITS-1:0] h);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 10);
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.obj_handle <= h;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (op != OP_UNUSED && !(op == OP_REPORT && h == 0))
			effective_items++;
	endtask

	// Handle choice leaning on the table edges and single-bit patterns.
	function automatic logic [HANDLE_BITS-1:0] pick_handle();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return HANDLE_BITS'(1);
			2: return HANDLE_BITS'(1) << $urandom_range(0, HANDLE_BITS - 1);
			default: return HANDLE_BITS'($urandom_range(1, OBJECT_COUNT - 1));
		endcase
	endfunction

	// One marking cycle: begin, report roots, then drain the grey stack while reporting children
	// drawn from a small set of objects, with an occasional null report, begin or unused word.
	task automatic run_mark_cycle();
		logic [HANDLE_BITS-1:0] objs [10];
		int kids;
		foreach (objs[i]) objs[i] = pick_handle();
		send_word(OP_BEGIN, HANDLE_BITS'($urandom));
		repeat ($urandom_range(1, 4)) send_word(OP_REPORT, objs[$urandom_range(0, 9)]);
		while (1) begin
			if (tracker.grey_head == 0) begin
				// Usually finish with an empty pop; sometimes leave the scan open.
				if ($urandom_range(0, 3) != 0)
					send_word(OP_NEXT, HANDLE_BITS'($urandom));
				break;
			end
			send_word(OP_NEXT, HANDLE_BITS'($urandom));
			kids = $urandom_range(0, 3);
			repeat (kids) begin
				if ($urandom_range(0, 7) == 0)
					send_word(OP_REPORT, '0);
				else
					send_word(OP_REPORT, objs[$urandom_range(0, 9)]);
			end
			if ($urandom_range(0, 15) == 0)
				send_word(OP_BEGIN, HANDLE_BITS'($urandom));
			if ($urandom_range(0, 19) == 0)
				send_word(OP_UNUSED, HANDLE_BITS'($urandom));
		end
	endtask

	// Reset, directed cases, random cycles, then drain and judge.
	initial begin
		tracker = new();
		burst_left = 0;
		effective_items = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_BEGIN;
		req_ch.obj_handle = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty pops, null and repeated reports, refused begin,
		// reports of the object in scan and of white objects, begin during a scan.
		send_word(OP_NEXT, '0);
		send_word(OP_REPORT, '0);
		send_word(OP_REPORT, '1);
		send_word(OP_REPORT, '1);
		send_word(OP_BEGIN, '0);
		send_word(OP_NEXT, '0);
		send_word(OP_REPORT, '1);
		send_word(OP_REPORT, 12'd1);
		send_word(OP_REPORT, 12'hAAA);
		send_word(OP_NEXT, '1);
		send_word(OP_REPORT, '1);
		send_word(OP_NEXT, '0);
		send_word(OP_BEGIN, '1);
		send_word(OP_REPORT, 12'd1);
		send_word(OP_REPORT, 12'h555);
		send_word(OP_REPORT, '1);
		send_word(OP_NEXT, '0);
		send_word(OP_NEXT, '0);
		send_word(OP_NEXT, '0);
		send_word(OP_NEXT, '0);
		send_word(OP_UNUSED, 12'hABC);
		send_word(OP_NEXT, '0);
		send_word(OP_REPORT, 12'h800);
		send_word(OP_NEXT, '0);
		send_word(OP_NEXT, '0);

		// Random part: mostly marking cycles, some raw noise.
		effective_items = 0;
		while (effective_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat (8) send_word(OP_BITS'($urandom_range(0, 3)),
					HANDLE_BITS'($urandom_range(0, OBJECT_COUNT - 1)));
			end else begin
				run_mark_cycle();
			end
		end
		req_ch.valid <= 1'b0;

		while (tracker.awaited_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0)
			$display("gc_tricolour_mark_engine_core verification clean");
		else
			$display("gc_tricolour_mark_engine_core verification failed");
		$finish;
	end

endmodule
